@@ rtl/i2a_pkg.sv @@
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, codes, widths and the digit-to-ASCII function of the
// integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2a_pkg;

    localparam int BIN_W      = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = BCD_DIGITS * 4;
    localparam int STEP_W     = $clog2(BIN_W);
    localparam int CNT_W      = $clog2(BCD_DIGITS + 1);

    localparam logic [1:0] CONV_HEX_LOWER  = 2'd0;
    localparam logic [1:0] CONV_HEX_UPPER  = 2'd1;
    localparam logic [1:0] CONV_DEC_UNSIGN = 2'd2;
    localparam logic [1:0] CONV_DEC_SIGNED = 2'd3;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    localparam logic [6:0] CHAR_ZERO    = 7'h30;
    localparam logic [6:0] CHAR_MINUS   = 7'h2d;
    localparam logic [6:0] CHAR_X_LOWER = 7'h78;
    localparam logic [6:0] CHAR_X_UPPER = 7'h58;
    localparam logic [6:0] CHAR_A_LOWER = 7'h61;
    localparam logic [6:0] CHAR_A_UPPER = 7'h41;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREFIX_ZERO,
        ST_PREFIX_X,
        ST_DIGITS
    } state_t;

    // Status of the binary-to-BCD converter toward the sequencer
    typedef struct packed {
        logic             busy;
        logic [BCD_W-1:0] bcd;
    } dbl_status_t;

    function automatic logic [6:0] digit_to_ascii(input logic [3:0] d, input logic upper);
        logic [6:0] base;
        if (d < 4'd10) begin
            digit_to_ascii = CHAR_ZERO + {3'b000, d};
        end else begin
            base = upper ? CHAR_A_UPPER : CHAR_A_LOWER;
            digit_to_ascii = base + {3'b000, d - 4'd10};
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/integer_to_ascii_formatter_unit.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Prints a 32-bit value as hex or decimal ASCII, one character per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one transfer carries value, conversion (x, X, u, d), size
//   code and the alternate-form and zero-fill flags. s_ready is high only
//   while the unit is idle; one item is worked on at a time.
//   m_* channel: one transfer per character, m_last marks the final one.
//   Up to 11 characters per item.
// Sequence:
//   Hex: prefix characters and digits leave one per cycle while m_ready
//   allows; suppressed leading zero nibbles are dropped one at a time.
//   Decimal: a bit-serial binary-to-BCD converter shifts in all 32 bits,
//   then the 10 BCD digits are loaded and scanned one per cycle while
//   m_ready allows. A minus sign goes out while the converter runs.
//   s_ready returns in the same cycle as the last character shows on m_*.
// Reset: aresetn (synchronous, active low) returns the sequencer to idle and
//   drops m_valid; an item in progress is discarded.
// Stall: a character waits in the output register while m_ready is low and
//   no new character is loaded; no character is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_formatter_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output      logic                        s_ready,
    input  wire logic [i2a_pkg::BIN_W-1:0]   s_value,
    input  wire logic [1:0]                  s_conversion,
    input  wire logic [1:0]                  s_size_code,
    input  wire logic                        s_alternate_form,
    input  wire logic                        s_zero_fill,
    output      logic                        m_valid,
    input  wire logic                        m_ready,
    output      logic [6:0]                  m_character,
    output      logic                        m_last
);
    import i2a_pkg::*;

    state_t            state_reg, state_next;
    logic [BCD_W-1:0]  digits_reg, digits_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic              suppress_reg, suppress_next;
    logic              seen_reg, seen_next;
    logic              upper_reg, upper_next;
    logic              sign_reg, sign_next;
    logic              out_valid_reg, out_valid_next;
    logic [6:0]        out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    logic              accept;
    logic              can_load;
    logic              dbl_start;
    logic [BIN_W-1:0]  dec_in;
    logic [BIN_W-1:0]  magnitude;
    logic              negative;
    logic [3:0]        cur_digit;
    dbl_status_t       dbl_status;

    i2a_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dbl_start),
        .bin     (dec_in),
        .status  (dbl_status)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign can_load = !out_valid_reg || m_ready;
    assign cur_digit = digits_reg[BCD_W-1 -: 4];

    assign negative  = (s_conversion == CONV_DEC_SIGNED) && s_value[BIN_W-1];
    assign magnitude = negative ? (BIN_W'(0) - s_value) : s_value;

    always_comb begin
        case (s_size_code)
            SIZE_BYTE: dec_in = {24'd0, magnitude[7:0]};
            SIZE_HALF: dec_in = {16'd0, magnitude[15:0]};
            default:   dec_in = magnitude;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        digits_next    = digits_reg;
        remain_next    = remain_reg;
        suppress_next  = suppress_reg;
        seen_next      = seen_reg;
        upper_next     = upper_reg;
        sign_next      = sign_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        dbl_start      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    seen_next  = 1'b0;
                    upper_next = (s_conversion == CONV_HEX_UPPER);
                    if (s_conversion[1]) begin
                        dbl_start     = 1'b1;
                        sign_next     = negative;
                        suppress_next = 1'b1;
                        remain_next   = CNT_W'(BCD_DIGITS);
                        state_next    = ST_CONV;
                    end else begin
                        sign_next     = 1'b0;
                        suppress_next = !(s_zero_fill && (s_value != '0));
                        // Align the top nibble of the size at the digit head
                        case (s_size_code)
                            SIZE_BYTE: begin
                                digits_next = {s_value[7:0], 32'd0};
                                remain_next = CNT_W'(2);
                            end
                            SIZE_HALF: begin
                                digits_next = {s_value[15:0], 24'd0};
                                remain_next = CNT_W'(4);
                            end
                            default: begin
                                digits_next = {s_value, 8'd0};
                                remain_next = CNT_W'(8);
                            end
                        endcase
                        state_next = s_alternate_form ? ST_PREFIX_ZERO : ST_DIGITS;
                    end
                end
            end

            ST_CONV: begin
                if (sign_reg && can_load) begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    sign_next      = 1'b0;
                end
                if (!dbl_status.busy && !sign_reg) begin
                    digits_next = dbl_status.bcd;
                    state_next  = ST_DIGITS;
                end
            end

            ST_PREFIX_ZERO: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_ZERO;
                    out_last_next  = 1'b0;
                    state_next     = ST_PREFIX_X;
                end
            end

            ST_PREFIX_X: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_char_next  = upper_reg ? CHAR_X_UPPER : CHAR_X_LOWER;
                    out_last_next  = 1'b0;
                    state_next     = ST_DIGITS;
                end
            end

            ST_DIGITS: begin
                if (suppress_reg && !seen_reg && (cur_digit == 4'd0)
                        && (remain_reg != CNT_W'(1))) begin
                    // drop a leading zero
                    digits_next = {digits_reg[BCD_W-5:0], 4'd0};
                    remain_next = remain_reg - 1'b1;
                end else if (can_load) begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_to_ascii(cur_digit, upper_reg);
                    out_last_next  = (remain_reg == CNT_W'(1));
                    seen_next      = 1'b1;
                    digits_next    = {digits_reg[BCD_W-5:0], 4'd0};
                    remain_next    = remain_reg - 1'b1;
                    if (remain_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sign_reg      <= 1'b0;
            seen_reg      <= 1'b0;
            remain_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sign_reg      <= sign_next;
            seen_reg      <= seen_next;
            remain_reg    <= remain_next;
        end
    end

    always_ff @(posedge aclk) begin
        digits_reg   <= digits_next;
        suppress_reg <= suppress_next;
        upper_reg    <= upper_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_character = out_char_reg;
    assign m_last      = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/i2a_dabble.sv @@
// ----------------------------------------------------------------------------
// i2a_dabble
// Serial binary-to-BCD converter: one input bit per cycle, shift-and-add-3.
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_dabble (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [i2a_pkg::BIN_W-1:0]   bin,
    output i2a_pkg::dbl_status_t             status
);
    import i2a_pkg::*;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [BIN_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [BCD_W-1:0]  adjusted;

    // Add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_reg[i*4 +: 4] >= 4'd5) begin
                adjusted[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end else begin
                adjusted[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            bin_next  = bin;
            bcd_next  = '0;
        end else if (busy_reg) begin
            bcd_next  = {adjusted[BCD_W-2:0], bin_reg[BIN_W-1]};
            bin_next  = {bin_reg[BIN_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(BIN_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign status.busy = busy_reg;
    assign status.bcd  = bcd_reg;

endmodule

`default_nettype wire
